// File: hw/rtl/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, codes and default sizes for the key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int FUNC_W = 2;
   localparam int OCC_W  = 5;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic [FUNC_W-1:0] FUNC_PUT      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_ERASE    = 2'd3;

   localparam logic [2:0] CELL_NOP    = 3'd0;
   localparam logic [2:0] CELL_LOOK   = 3'd1;
   localparam logic [2:0] CELL_TOUCH  = 3'd2;
   localparam logic [2:0] CELL_DROP   = 3'd3;
   localparam logic [2:0] CELL_INSERT = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       wr_value;
      logic       evict_en;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: hw/rtl/lkvc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_if
// Valid/ready channels: request, response and capacity register write.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [VALUE_BITS-1:0] read_value;
   logic [OCC_W-1:0]      occupancy;

   modport source (output valid, output found, output read_value, output occupancy,
                   input ready);
   modport sink   (input valid, input found, input read_value, input occupancy,
                   output ready);
endinterface

interface lkvc_csr_if import lkvc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lkvc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell
// One cache entry. Matches are collected down the row through neighbor links.
// ----------------------------------------------------------------------------
module lkvc_cell import lkvc_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int RANK_W     = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_cmd_type          cmd,
   input  wire logic [KEY_BITS-1:0]   key,
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire logic [RANK_W-1:0]     ref_rank,
   input  wire logic [RANK_W-1:0]     last_rank,
   input  wire logic                  hit_prev,
   input  wire logic [RANK_W-1:0]     rank_prev,
   input  wire logic [VALUE_BITS-1:0] value_prev,
   input  wire logic                  free_prev,
   output logic                       hit_next,
   output logic [RANK_W-1:0]          rank_next,
   output logic [VALUE_BITS-1:0]      value_next,
   output logic                       free_next,
   output logic                       valid_o
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic                  hit_ff, hit_in;
   logic                  ins_ff, ins_in;
   logic                  victim_ff, victim_in;

   logic hit_here;
   logic victim_here;
   logic free_here;

   assign hit_here    = valid_ff && (key_ff == key);
   assign victim_here = valid_ff && (rank_ff == last_rank) && cmd.evict_en;
   assign free_here   = !valid_ff || victim_here;

   assign hit_next   = hit_prev || hit_here;
   assign rank_next  = rank_prev | (hit_here ? rank_ff : '0);
   assign value_next = value_prev | (hit_here ? value_ff : '0);
   assign free_next  = free_prev || free_here;
   assign valid_o    = valid_ff;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      rank_in   = rank_ff;
      hit_in    = hit_ff;
      ins_in    = ins_ff;
      victim_in = victim_ff;
      case (cmd.op)
         CELL_LOOK: begin
            hit_in    = hit_here;
            ins_in    = free_here && !free_prev;
            victim_in = victim_here;
         end
         CELL_TOUCH: begin
            if (hit_ff) begin
               rank_in = '0;
               if (cmd.wr_value) begin
                  value_in = value;
               end
            end else if (valid_ff && (rank_ff < ref_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CELL_DROP: begin
            if (hit_ff) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff > ref_rank)) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         CELL_INSERT: begin
            if (ins_ff) begin
               valid_in = 1'b1;
               key_in   = key;
               value_in = value;
               rank_in  = '0;
            end else if (victim_ff) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rank_ff   <= '0;
         hit_ff    <= 1'b0;
         ins_ff    <= 1'b0;
         victim_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rank_ff   <= rank_in;
         hit_ff    <= hit_in;
         ins_ff    <= ins_in;
         victim_ff <= victim_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/lru_key_value_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Order: accept, row lookup, row update; response registered with the update.
// A new item is taken only after the update; an unread response stalls it.
// The lookup cycle ripples hit and free-slot flags through the row of cells.
// Reset: synchronous; all entries invalid, occupancy 0, capacity 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core import lkvc_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lkvc_req_if.sink  req_ch,
   lkvc_rsp_if.source rsp_ch,
   lkvc_csr_if.sink  csr_ch
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CAP_W-1:0]      cap_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  hit_ff;
   logic [RANK_W-1:0]     hit_rank_ff;
   logic [VALUE_BITS-1:0] hit_value_ff;
   logic                  evict_ff;
   logic                  rsp_valid_ff;
   logic                  found_ff;
   logic [VALUE_BITS-1:0] read_value_ff, read_value_in;
   logic [OCC_W-1:0]      occ_ff;

   logic [CNT_W-1:0]      cap_eff;
   logic                  evict_en;
   logic                  advance;
   cell_cmd_type          cmd;
   logic [RANK_W-1:0]     last_rank;

   logic                  hit_link   [ENTRIES+1];
   logic [RANK_W-1:0]     rank_link  [ENTRIES+1];
   logic [VALUE_BITS-1:0] value_link [ENTRIES+1];
   logic                  free_link  [ENTRIES+1];
   logic [ENTRIES-1:0]    valid_vec;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = found_ff;
   assign rsp_ch.read_value = read_value_ff;
   assign rsp_ch.occupancy  = occ_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign evict_en  = (func_ff == FUNC_PUT) && (count_ff >= cap_eff);
   assign last_rank = RANK_W'(count_ff - 1'b1);
   assign advance   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      cmd           = '0;
      count_in      = count_ff;
      read_value_in = '0;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.op       = CELL_LOOK;
            cmd.evict_en = evict_en;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            if (advance) begin
               state_in = ST_IDLE;
               case (func_ff)
                  FUNC_PUT: begin
                     if (hit_ff) begin
                        cmd.op       = CELL_TOUCH;
                        cmd.wr_value = 1'b1;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff - CNT_W'(evict_ff) + 1'b1;
                     end
                  end
                  FUNC_GET: begin
                     if (hit_ff) begin
                        cmd.op        = CELL_TOUCH;
                        read_value_in = hit_value_ff;
                     end
                  end
                  FUNC_ERASE: begin
                     if (hit_ff) begin
                        cmd.op   = CELL_DROP;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign hit_link[0]   = 1'b0;
   assign rank_link[0]  = '0;
   assign value_link[0] = '0;
   assign free_link[0]  = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .RANK_W     (RANK_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key_ff),
         .value      (value_ff),
         .ref_rank   (hit_rank_ff),
         .last_rank  (last_rank),
         .hit_prev   (hit_link[i]),
         .rank_prev  (rank_link[i]),
         .value_prev (value_link[i]),
         .free_prev  (free_link[i]),
         .hit_next   (hit_link[i+1]),
         .rank_next  (rank_link[i+1]),
         .value_next (value_link[i+1]),
         .free_next  (free_link[i+1]),
         .valid_o    (valid_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         evict_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_ch.valid) begin
            cap_ff <= csr_ch.data;
         end
         if (state_ff == ST_LOOK) begin
            hit_ff   <= hit_link[ENTRIES];
            evict_ff <= evict_en;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         func_ff  <= req_ch.func;
         key_ff   <= req_ch.key;
         value_ff <= req_ch.value;
      end
      if (state_ff == ST_LOOK) begin
         hit_rank_ff  <= rank_link[ENTRIES];
         hit_value_ff <= value_link[ENTRIES];
      end
      if (advance) begin
         found_ff      <= hit_ff;
         read_value_ff <= read_value_in;
         occ_ff        <= OCC_W'(count_in);
      end
   end

`ifndef SYNTH
   a_count_matches_valid : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("occupancy count differs from valid entries");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ENTRIES))
      else $error("occupancy count beyond entries");

   a_rsp_from_exec : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside update cycle");

   a_accept_to_look : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_LOOK))
      else $error("accepted item did not start lookup");
`endif

endmodule
`default_nettype wire
